[src/slrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slrd_pkg: shared types for the status/length record deframer
// Result kinds, the input word and the result word shared by core and top.
// ----------------------------------------------------------------------------
package slrd_pkg;

  // Reset value of the length limit register (20 MiB).
  localparam logic [31:0] DEFAULT_MAX_VALUE_LENGTH = 32'd20971520;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_VALUE_LENGTH = 1'b0;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_VALUE  = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_REJECT = 3'd3,
    KIND_TRUNC  = 3'd4,
    KIND_LIMIT  = 3'd5,
    KIND_MANY   = 3'd6
  } kind_t;

  // One accepted body byte with its side-band fields.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_body;
    logic        last_of_body;
    logic [7:0]  framing_skip;
    logic [15:0] key_skip;
    logic [7:0]  extras_skip;
    logic        body_accepted;
  } in_item_t;

  // One result word, with a flag that says whether the byte produced one.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [3:0]  entry_index;
    logic [15:0] entry_stat;
    logic [7:0]  value_byte;
    logic        last_of_entry;
    logic        body_end;
  } result_t;

endpackage
`default_nettype wire

[src/slrd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slrd_core: parse state of the deframer
// Holds the body parse state and works out the result of each accepted byte
// in one pass of logic. State advances only when a word is accepted.
// ----------------------------------------------------------------------------
module slrd_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire slrd_pkg::in_item_t item,
  input  wire logic [31:0]      max_value_length,
  output slrd_pkg::result_t     res
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_HEADER = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DROP   = 3'd4,
    PH_REJECT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_LIMIT = 2'd2,
    ERR_MANY  = 2'd3
  } err_t;

  phase_t            phase_r, phase_nxt;
  logic [16:0]       skip_r, skip_nxt;
  logic [2:0]        hcnt_r, hcnt_nxt;
  logic [15:0]       status_r, status_nxt;
  logic [31:0]       length_r, length_nxt;
  logic [31:0]       remain_r, remain_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  err_t              err_r, err_nxt;
  slrd_pkg::result_t res_c;

  // Build a result word; the entry index is the entry count modulo 16.
  function automatic slrd_pkg::result_t make_res(slrd_pkg::kind_t k,
                                                 logic [CNT_W-1:0] cnt,
                                                 logic [15:0] st,
                                                 logic [7:0] vb,
                                                 logic eol,
                                                 logic last);
    slrd_pkg::result_t r;
    logic [CNT_W+3:0]  cnt_ext;
    cnt_ext         = {4'b0000, cnt};
    r.valid         = 1'b1;
    r.kind          = k;
    r.entry_index   = cnt_ext[3:0];
    r.entry_stat    = st;
    r.value_byte    = vb;
    r.last_of_entry = eol;
    r.body_end      = last;
    return r;
  endfunction

  // Map a held error to the kind reported at the body end.
  function automatic slrd_pkg::kind_t err_kind(err_t e);
    slrd_pkg::kind_t k;
    case (e)
      ERR_LIMIT: k = slrd_pkg::KIND_LIMIT;
      ERR_MANY:  k = slrd_pkg::KIND_MANY;
      default:   k = slrd_pkg::KIND_TRUNC;
    endcase
    return k;
  endfunction

  // Next state and result for the byte on the input.
  always_comb begin
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    hcnt_nxt   = hcnt_r;
    status_nxt = status_r;
    length_nxt = length_r;
    remain_nxt = remain_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    res_c      = '0;

    // A first byte always restarts the body and then is parsed as usual.
    if (item.first_of_body) begin
      skip_nxt   = 17'(item.framing_skip) + 17'(item.key_skip)
                 + 17'(item.extras_skip);
      hcnt_nxt   = '0;
      status_nxt = '0;
      length_nxt = '0;
      remain_nxt = '0;
      count_nxt  = '0;
      err_nxt    = ERR_NONE;
      if (!item.body_accepted) begin
        phase_nxt = PH_REJECT;
      end else if (skip_nxt != 17'd0) begin
        phase_nxt = PH_SKIP;
      end else begin
        phase_nxt = PH_HEADER;
      end
    end

    case (phase_nxt)
      PH_REJECT: begin
        if (item.last_of_body) begin
          phase_nxt = PH_IDLE;
          res_c = make_res(slrd_pkg::KIND_REJECT, count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
        end
      end
      PH_DROP: begin
        if (item.last_of_body) begin
          phase_nxt = PH_IDLE;
          res_c = make_res(err_kind(err_nxt), count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_nxt - 17'd1;
        if (skip_nxt == 17'd0) begin
          phase_nxt = PH_HEADER;
        end
        if (item.last_of_body) begin
          phase_nxt = PH_IDLE;
          res_c = make_res(slrd_pkg::KIND_DONE, count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
        end
      end
      PH_HEADER: begin
        // Two status bytes, then four length bytes, most significant first.
        if (hcnt_nxt < 3'd2) begin
          status_nxt = {status_nxt[7:0], item.data_byte};
          if (hcnt_nxt == 3'd0) begin
            length_nxt = '0;
          end
        end else begin
          length_nxt = {length_nxt[23:0], item.data_byte};
        end
        hcnt_nxt = hcnt_nxt + 3'd1;
        if (hcnt_nxt < 3'd6) begin
          if (item.last_of_body) begin
            phase_nxt = PH_IDLE;
            hcnt_nxt  = '0;
            res_c = make_res(slrd_pkg::KIND_TRUNC, count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
          end
        end else begin
          hcnt_nxt = '0;
          // The entry table limit is checked before the length limit.
          if (count_nxt >= CNT_W'(MAX_ENTRIES)) begin
            err_nxt = ERR_MANY;
          end else if (length_nxt >= max_value_length) begin
            err_nxt = ERR_LIMIT;
          end
          if (err_nxt != ERR_NONE) begin
            phase_nxt = PH_DROP;
            if (item.last_of_body) begin
              phase_nxt = PH_IDLE;
              res_c = make_res(err_kind(err_nxt), count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
            end
          end else if (length_nxt == 32'd0) begin
            res_c = make_res(slrd_pkg::KIND_EMPTY, count_nxt, status_nxt, 8'd0, 1'b1,
                             item.last_of_body);
            count_nxt = count_nxt + CNT_W'(1);
            if (item.last_of_body) begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            remain_nxt = length_nxt;
            phase_nxt  = PH_VALUE;
            if (item.last_of_body) begin
              phase_nxt = PH_IDLE;
              res_c = make_res(slrd_pkg::KIND_TRUNC, count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
            end
          end
        end
      end
      PH_VALUE: begin
        remain_nxt = remain_nxt - 32'd1;
        if (remain_nxt == 32'd0) begin
          res_c = make_res(slrd_pkg::KIND_VALUE, count_nxt, status_nxt, item.data_byte,
                           1'b1, item.last_of_body);
          count_nxt = count_nxt + CNT_W'(1);
          phase_nxt = item.last_of_body ? PH_IDLE : PH_HEADER;
        end else if (item.last_of_body) begin
          // The byte on a truncating end is dropped.
          phase_nxt = PH_IDLE;
          res_c = make_res(slrd_pkg::KIND_TRUNC, count_nxt, status_nxt, 8'd0, 1'b0, 1'b1);
        end else begin
          res_c = make_res(slrd_pkg::KIND_VALUE, count_nxt, status_nxt, item.data_byte,
                           1'b0, 1'b0);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign res = res_c;

  // Parse state moves only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      skip_r   <= '0;
      hcnt_r   <= '0;
      status_r <= '0;
      length_r <= '0;
      remain_r <= '0;
      count_r  <= '0;
      err_r    <= ERR_NONE;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      skip_r   <= skip_nxt;
      hcnt_r   <= hcnt_nxt;
      status_r <= status_nxt;
      length_r <= length_nxt;
      remain_r <= remain_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

[src/status_length_record_deframer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_length_record_deframer_top: response body record deframer
// Splits a byte stream of response bodies into status/length/value entries.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one body byte per word, with the skip sizes and the
//   accept flag sampled on the word that marks the first byte of a body and
//   in_tlast on the final byte. The out_ stream carries at most one result
//   word per input word: a value byte, an empty entry, or an end-of-body
//   report (done, rejected, truncated, length over limit, too many entries),
//   with out_tlast set on the result caused by the final body byte.
//   The result of an accepted word is registered and shown on out_ in the
//   cycle after it is accepted. Throughput is one word per cycle; the single
//   output register is refilled in the cycle it is drained, so only a stalled
//   receiver holding a full output register stops the input.
//   The length limit is written over the cfg_ APB port at address 0; the user
//   must write it only while the block is idle, as the block does not enforce it.
//   Reset clears the parse state to idle, empties the output register and
//   loads the length limit with 20 MiB.
// ----------------------------------------------------------------------------
module status_length_record_deframer_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] data_byte, [15:8] framing_skip, [31:16] key_skip,
  // [39:32] extras_skip
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tlast,
  // [0] first_of_body, [1] body_accepted
  input  wire logic [1:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] entry_index, [19:4] entry_stat, [27:20] value_byte, [31:28] zero
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  // [2:0] kind, [3] last_of_entry
  output logic [3:0]       out_tuser,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic               in_fire;
  logic               cfg_wr;
  logic [31:0]        max_len_r;
  slrd_pkg::in_item_t item;
  slrd_pkg::result_t  res;
  slrd_pkg::result_t  out_r;
  logic               out_valid_r;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == slrd_pkg::REG_MAX_VALUE_LENGTH) ? max_len_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= slrd_pkg::DEFAULT_MAX_VALUE_LENGTH;
    end else if (cfg_wr && cfg_paddr[2] == slrd_pkg::REG_MAX_VALUE_LENGTH) begin
      max_len_r <= cfg_pwdata;
    end
  end

  // Input word unpacking and handshake.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign item.data_byte     = in_tdata[7:0];
  assign item.framing_skip  = in_tdata[15:8];
  assign item.key_skip      = in_tdata[31:16];
  assign item.extras_skip   = in_tdata[39:32];
  assign item.first_of_body = in_tuser[0];
  assign item.body_accepted = in_tuser[1];
  assign item.last_of_body  = in_tlast;

  slrd_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .item            (item),
    .max_value_length(max_len_r),
    .res             (res)
  );

  // Output register: loads on an accepted word, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.value_byte, out_r.entry_stat, out_r.entry_index};
  assign out_tlast  = out_r.body_end;
  assign out_tuser  = {out_r.last_of_entry, out_r.kind};

endmodule
`default_nettype wire
